### rtl/lmcr_pkg.sv
// Shared types, microcode program, font glyph table and rotation function.
`default_nettype none

package lmcr_pkg;

  localparam int MODULES_DEFAULT = 4;

  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd128;

  // One glyph: row 0 is the leftmost (most significant) byte, column c is bit 7 - c.
  typedef logic [0:7][7:0] glyph_t;

  // Datapath operation selected by the current control word.
  typedef enum logic [1:0] {
    OP_WAIT  = 2'd0,
    OP_ROT   = 2'd1,
    OP_WRITE = 2'd2,
    OP_EMIT  = 2'd3
  } uop_t;

  // Status condition that makes the sequencer jump; otherwise it holds the step.
  typedef enum logic [1:0] {
    COND_IN_GO      = 2'd0,
    COND_TURNS_ZERO = 2'd1,
    COND_ROW_LAST   = 2'd2,
    COND_EMIT_LAST  = 2'd3
  } cond_t;

  typedef logic [1:0] step_t;

  localparam step_t STEP_WAIT  = 2'd0;
  localparam step_t STEP_ROT   = 2'd1;
  localparam step_t STEP_WRITE = 2'd2;
  localparam step_t STEP_EMIT  = 2'd3;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic in_go;
    logic turns_zero;
    logic row_last;
    logic emit_last;
  } stat_t;

  // The control program: each step repeats its operation until its condition jumps.
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    unique case (step)
      STEP_WAIT:  w = '{op: OP_WAIT,  cond: COND_IN_GO,      target: STEP_ROT};
      STEP_ROT:   w = '{op: OP_ROT,   cond: COND_TURNS_ZERO, target: STEP_WRITE};
      STEP_WRITE: w = '{op: OP_WRITE, cond: COND_ROW_LAST,   target: STEP_EMIT};
      STEP_EMIT:  w = '{op: OP_EMIT,  cond: COND_EMIT_LAST,  target: STEP_WAIT};
    endcase
    return w;
  endfunction

  // One quarter turn: transpose, then reverse the row order.
  function automatic glyph_t quarter_turn(input glyph_t g);
    glyph_t t;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        t[r][7 - c] = g[c][r];
      end
    end
    return t;
  endfunction

  // Font table indexed by character code minus 32; unlisted entries are blank.
  function automatic glyph_t font_glyph(input logic [6:0] idx);
    glyph_t g;
    case (idx)
      7'd1:  g = 64'h1800_1818_3c3c_1800;
      7'd2:  g = 64'h0000_0000_286c_6c00;
      7'd3:  g = 64'h6c6c_fe6c_fe6c_6c00;
      7'd4:  g = 64'h103c_4038_0478_1000;
      7'd5:  g = 64'h6066_0c18_3066_0600;
      7'd6:  g = 64'hfc66_a614_3c66_3c00;
      7'd7:  g = 64'h0000_000c_1818_1800;
      7'd8:  g = 64'h6030_1818_1830_6000;
      7'd9:  g = 64'h060c_1818_180c_0600;
      7'd10: g = 64'h006c_38fe_386c_0000;
      7'd11: g = 64'h0010_107c_1010_0000;
      7'd12: g = 64'h060c_0c0c_0000_0000;
      7'd13: g = 64'h0000_003c_0000_0000;
      7'd14: g = 64'h0606_0000_0000_0000;
      7'd15: g = 64'h0006_0c18_3060_0000;
      7'd16: g = 64'h3c66_666e_7666_3c00;
      7'd17: g = 64'h7e18_1818_1c18_1800;
      7'd18: g = 64'h7e06_0c30_6066_3c00;
      7'd19: g = 64'h3c66_6038_6066_3c00;
      7'd20: g = 64'h3030_7e32_3438_3000;
      7'd21: g = 64'h3c66_6060_3e06_7e00;
      7'd22: g = 64'h3c66_663e_0666_3c00;
      7'd23: g = 64'h1818_1830_3066_7e00;
      7'd24: g = 64'h3c66_663c_6666_3c00;
      7'd25: g = 64'h3c66_607c_6666_3c00;
      7'd26: g = 64'h0018_1800_1818_0000;
      7'd27: g = 64'h0c18_1800_1818_0000;
      7'd28: g = 64'h6030_180c_1830_6000;
      7'd29: g = 64'h6030_180c_1830_6000;
      7'd30: g = 64'h060c_1830_180c_0600;
      7'd31: g = 64'h1800_1838_6066_3c00;
      7'd32: g = 64'h003c_421a_3a22_1c00;
      7'd33: g = 64'h6666_667e_6666_3c00;
      7'd34: g = 64'h3e66_663e_6666_3e00;
      7'd35: g = 64'h3c66_0606_0666_3c00;
      7'd36: g = 64'h3e66_6666_6666_3e00;
      7'd37: g = 64'h7e06_063e_0606_7e00;
      7'd38: g = 64'h0606_063e_0606_7e00;
      7'd39: g = 64'h3c66_7606_0666_3c00;
      7'd40: g = 64'h6666_667e_6666_6600;
      7'd41: g = 64'h3c18_1818_1818_3c00;
      7'd42: g = 64'h1c36_3630_3030_7800;
      7'd43: g = 64'h6636_1e0e_1e36_6600;
      7'd44: g = 64'h7e06_0606_0606_0600;
      7'd45: g = 64'hc6c6_c6d6_feee_c600;
      7'd46: g = 64'hc6c6_e6f6_dece_c600;
      7'd47: g = 64'h3c66_6666_6666_3c00;
      7'd48: g = 64'h0606_3e66_6666_3e00;
      7'd49: g = 64'h603c_7666_6666_3c00;
      7'd50: g = 64'h6636_1e3e_6666_3e00;
      7'd51: g = 64'h3c66_603c_0666_3c00;
      7'd52: g = 64'h1818_1818_185a_7e00;
      7'd53: g = 64'h7c66_6666_6666_6600;
      7'd54: g = 64'h183c_6666_6666_6600;
      7'd55: g = 64'hc6ee_fed6_c6c6_c600;
      7'd56: g = 64'hc6c6_6c38_6cc6_c600;
      7'd57: g = 64'h1818_183c_6666_6600;
      7'd58: g = 64'h7e06_0c18_3060_7e00;
      7'd59: g = 64'h7818_1818_1818_7800;
      7'd60: g = 64'h0060_3018_0c06_0000;
      7'd61: g = 64'h0060_3018_0c06_0000;
      7'd62: g = 64'h0000_0082_4428_1000;
      7'd63: g = 64'h3c00_0000_0000_0000;
      7'd64: g = 64'h0000_0000_6030_3000;
      7'd65: g = 64'h7c66_7c60_3c00_0000;
      7'd66: g = 64'h3e66_663e_0606_0600;
      7'd67: g = 64'h3c66_0666_3c00_0000;
      7'd68: g = 64'h7c66_667c_6060_6000;
      7'd69: g = 64'h3c06_7e66_3c00_0000;
      7'd70: g = 64'h0c0c_3e0c_0c6c_3800;
      7'd71: g = 64'h3c60_7c66_667c_0000;
      7'd72: g = 64'h6666_663e_0606_0600;
      7'd73: g = 64'h3c18_1818_0018_0000;
      7'd74: g = 64'h1c36_3630_3000_3000;
      7'd75: g = 64'h6636_1e36_6606_0600;
      7'd76: g = 64'h1818_1818_1818_1800;
      7'd77: g = 64'hd6d6_feee_c600_0000;
      7'd78: g = 64'h6666_667e_3e00_0000;
      7'd79: g = 64'h3c66_6666_3c00_0000;
      7'd80: g = 64'h0606_3e66_663e_0000;
      7'd81: g = 64'hf0b0_3c36_363c_0000;
      7'd82: g = 64'h0606_6666_3e00_0000;
      7'd83: g = 64'h3e40_3c02_7c00_0000;
      7'd84: g = 64'h1818_187e_1818_0000;
      7'd85: g = 64'h7c66_6666_6600_0000;
      7'd86: g = 64'h183c_6666_0000_0000;
      7'd87: g = 64'h7cd6_d6d6_c600_0000;
      7'd88: g = 64'h663c_183c_6600_0000;
      7'd89: g = 64'h3c60_7c66_6600_0000;
      7'd90: g = 64'h3c0c_1830_3c00_0000;
      7'd91: g = 64'h7018_180c_1818_7000;
      7'd92: g = 64'h0018_1818_1818_1800;
      7'd93: g = 64'h0e18_1830_1818_0e00;
      7'd94: g = 64'h0000_0036_5c00_0000;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

### rtl/led_matrix_char_rotate_refresh_top.sv
// Top level of the LED matrix character generator with rotation and chain refresh.
`default_nettype none

// Each transfer on the input channel names a character, a module of the daisy
// chain and a number of quarter turns. The block looks up the 8x8 glyph, rotates
// it, stores its eight rows in that module's slot of the frame buffer and then
// refreshes the whole chain: for each column 1 to 8 it sends one address/data
// pair per module in chain order, with frame_end on the last module of each
// column and last on the very last pair. Character codes outside 32 to 128 show
// as blank; a module number of zero or above MODULES leaves the buffer alone but
// the refresh is still sent. The frame buffer reads as all zeros after reset.
// A small microcode program steps through four phases (wait, rotate, write,
// refresh): it accepts the item, turns the glyph a quarter at a time until the
// turn count is zero, writes the eight rows one at a time through the single
// write port of the frame buffer, and makes one buffer read per result. The
// last two results drain through the read and output registers while the next
// item is taken. in_stall is high during reset and for the whole run of an
// item; stalls on the output channel hold the refresh phase while the output
// register is full.
module led_matrix_char_rotate_refresh_top #(
  parameter int MODULES = lmcr_pkg::MODULES_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] char_code,
  input  wire logic [2:0] module_number,
  input  wire logic [1:0] quarter_turns,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      reg_address,
  output logic [7:0]      reg_data,
  output logic            frame_end,
  output logic            last
);
  import lmcr_pkg::*;

  localparam int KW = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int AW = $clog2(MODULES * 8);

  uop_t          op;
  stat_t         stat;
  logic          turns_zero;
  logic          row_last;
  logic          emit_last;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  // Items are only taken out of reset while the program waits at its first step.
  assign in_stall = rst || (op != OP_WAIT);

  assign stat.in_go      = in_valid && !in_stall;
  assign stat.turns_zero = turns_zero;
  assign stat.row_last   = row_last;
  assign stat.emit_last  = emit_last;

  lmcr_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .op   (op)
  );

  lmcr_glyph #(
    .MODULES (MODULES),
    .KW      (KW),
    .AW      (AW)
  ) u_glyph (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .in_go         (stat.in_go),
    .char_code     (char_code),
    .module_number (module_number),
    .quarter_turns (quarter_turns),
    .turns_zero    (turns_zero),
    .row_last      (row_last),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  lmcr_fbuf #(
    .MODULES (MODULES),
    .KW      (KW),
    .AW      (AW)
  ) u_fbuf (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .emit_last   (emit_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .reg_address (reg_address),
    .reg_data    (reg_data),
    .frame_end   (frame_end),
    .last        (last)
  );

endmodule

`default_nettype wire

### rtl/lmcr_seq.sv
// Microcode sequencer: step counter, program table and conditional jumps.
`default_nettype none

module lmcr_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lmcr_pkg::stat_t stat,
  output lmcr_pkg::uop_t      op
);
  import lmcr_pkg::*;

  step_t  step;
  step_t  step_next;
  uword_t cw;
  logic   jump;

  assign cw = ucode(step);
  assign op = cw.op;

  always_comb begin
    unique case (cw.cond)
      COND_IN_GO:      jump = stat.in_go;
      COND_TURNS_ZERO: jump = stat.turns_zero;
      COND_ROW_LAST:   jump = stat.row_last;
      COND_EMIT_LAST:  jump = stat.emit_last;
    endcase
    step_next = jump ? cw.target : step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

### rtl/lmcr_glyph.sv
// Glyph datapath: font lookup, rotation register and frame buffer write port.
`default_nettype none

module lmcr_glyph #(
  parameter int MODULES = lmcr_pkg::MODULES_DEFAULT,
  parameter int KW      = (MODULES > 1) ? $clog2(MODULES) : 1,
  parameter int AW      = $clog2(MODULES * 8)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lmcr_pkg::uop_t op,
  input  wire logic           in_go,
  input  wire logic [7:0]     char_code,
  input  wire logic [2:0]     module_number,
  input  wire logic [1:0]     quarter_turns,
  output logic                turns_zero,
  output logic                row_last,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [7:0]          wr_data
);
  import lmcr_pkg::*;

  glyph_t     glyph;
  logic [1:0] turns;
  logic [2:0] row;
  logic [KW-1:0] slot;
  logic       mod_ok;

  logic [6:0] idx;
  logic [3:0] slot_full;
  logic       code_ok;

  // Codes outside the font range map to the blank glyph at index zero.
  assign code_ok   = (char_code >= FIRST_CODE) && (char_code <= LAST_CODE);
  assign idx       = code_ok ? 7'(char_code - FIRST_CODE) : 7'd0;
  assign slot_full = 4'(MODULES) - {1'b0, module_number};

  assign turns_zero = (turns == 2'd0);
  assign row_last   = (row == 3'd7);
  assign wr_en      = (op == OP_WRITE) && mod_ok;
  assign wr_addr    = AW'({slot, row});
  assign wr_data    = glyph[row];

  always_ff @(posedge clk) begin
    if (rst) begin
      turns <= 2'd0;
      row   <= 3'd0;
    end else begin
      if (op == OP_WAIT && in_go) begin
        turns <= quarter_turns;
        row   <= 3'd0;
      end else if (op == OP_ROT && !turns_zero) begin
        turns <= turns - 2'd1;
      end else if (op == OP_WRITE) begin
        row <= row + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_WAIT && in_go) begin
      glyph  <= font_glyph(idx);
      slot   <= slot_full[KW-1:0];
      mod_ok <= (module_number != 3'd0) && ({1'b0, module_number} <= 4'(MODULES));
    end else if (op == OP_ROT && !turns_zero) begin
      glyph <= quarter_turn(glyph);
    end
  end

endmodule

`default_nettype wire

### rtl/lmcr_fbuf.sv
// Frame buffer memory with per-entry valid bits, refresh read pipe and output register.
`default_nettype none

module lmcr_fbuf #(
  parameter int MODULES = lmcr_pkg::MODULES_DEFAULT,
  parameter int KW      = (MODULES > 1) ? $clog2(MODULES) : 1,
  parameter int AW      = $clog2(MODULES * 8)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lmcr_pkg::uop_t op,
  input  wire logic           wr_en,
  input  wire logic [AW-1:0]  wr_addr,
  input  wire logic [7:0]     wr_data,
  output logic                emit_last,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [3:0]          reg_address,
  output logic [7:0]          reg_data,
  output logic                frame_end,
  output logic                last
);
  import lmcr_pkg::*;

  localparam int DEPTH = MODULES * 8;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld;

  logic [2:0]    col;
  logic [KW-1:0] chain;
  logic [AW-1:0] raddr;
  logic          chain_last;
  logic          advance;
  logic          issue;

  logic       rd_pend;
  logic [7:0] rd_data;
  logic       rd_ok;
  logic [2:0] rd_col;
  logic       rd_fe;
  logic       rd_last;

  assign raddr      = AW'({chain, col});
  assign chain_last = (chain == KW'(MODULES - 1));
  assign advance    = !out_valid || !out_stall;
  assign issue      = (op == OP_EMIT) && advance;
  assign emit_last  = issue && chain_last && (col == 3'd7);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      col       <= 3'd0;
      chain     <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (issue) begin
        if (chain_last) begin
          chain <= '0;
          col   <= col + 3'd1;
        end else begin
          chain <= chain + KW'(1);
        end
      end
      if (advance) begin
        rd_pend   <= issue;
        out_valid <= rd_pend;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_ok   <= vld[raddr];
      rd_col  <= col;
      rd_fe   <= chain_last;
      rd_last <= chain_last && (col == 3'd7);
    end
    if (advance && rd_pend) begin
      reg_address <= 4'({1'b0, rd_col}) + 4'd1;
      reg_data    <= rd_ok ? rd_data : 8'd0;
      frame_end   <= rd_fe;
      last        <= rd_last;
    end
  end

  a_no_write_during_refresh: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && issue))
    else $error("frame buffer written while refresh reads are issued");

  a_last_closes_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (frame_end && reg_address == 4'd8))
    else $error("final pair is not the last module of column eight");

  a_read_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (rd_pend && !advance) |=> (rd_pend && $stable(rd_col) && $stable(rd_fe)))
    else $error("read stage lost its entry while the output was stalled");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the LED matrix character generator with rotation and chain refresh.
module tb;

  // The testbench uses the block's default chain length.
  // The frame buffer holds eight row bytes per module.
  localparam int MODULES  = lmcr_pkg::MODULES_DEFAULT;
  localparam int BUF_ROWS = MODULES * 8;

  localparam int HALF_PERIOD = 10;

  // Character codes that have a glyph in the font; everything else shows blank.
  localparam logic [7:0] CODE_FIRST = 8'd32;
  localparam logic [7:0] CODE_LAST  = 8'd128;

  // Length of the one long output hold-off, in clock cycles.
  localparam int HOLDOFF_CYCLES = 400;

  // Cycles to wait after the last expected pair before a new phase or the end.
  // The block writes no pair that is not predicted, so a short margin is enough.
  localparam int SETTLE_CYCLES = 20;

  localparam longint LIMIT_TIME = 64'd20_000_000;

  // One glyph. Row 0 comes first and column c is bit 7 - c of a row byte.
  typedef logic [0:7][7:0] bitmap_t;

  // One address/data pair of the chain refresh, as seen on the output ports.
  typedef struct packed {
    logic [3:0] address;
    logic [7:0] data;
    logic       frame_end;
    logic       last;
  } refresh_pair_t;

  // Glyph table for codes 32 to 128, indexed by code minus 32. The last two
  // entries are blank.
  localparam logic [0:96][63:0] FONT_ROWS = {
    64'h0000_0000_0000_0000, 64'h1800_1818_3c3c_1800, 64'h0000_0000_286c_6c00,
    64'h6c6c_fe6c_fe6c_6c00, 64'h103c_4038_0478_1000, 64'h6066_0c18_3066_0600,
    64'hfc66_a614_3c66_3c00, 64'h0000_000c_1818_1800, 64'h6030_1818_1830_6000,
    64'h060c_1818_180c_0600, 64'h006c_38fe_386c_0000, 64'h0010_107c_1010_0000,
    64'h060c_0c0c_0000_0000, 64'h0000_003c_0000_0000, 64'h0606_0000_0000_0000,
    64'h0006_0c18_3060_0000, 64'h3c66_666e_7666_3c00, 64'h7e18_1818_1c18_1800,
    64'h7e06_0c30_6066_3c00, 64'h3c66_6038_6066_3c00, 64'h3030_7e32_3438_3000,
    64'h3c66_6060_3e06_7e00, 64'h3c66_663e_0666_3c00, 64'h1818_1830_3066_7e00,
    64'h3c66_663c_6666_3c00, 64'h3c66_607c_6666_3c00, 64'h0018_1800_1818_0000,
    64'h0c18_1800_1818_0000, 64'h6030_180c_1830_6000, 64'h6030_180c_1830_6000,
    64'h060c_1830_180c_0600, 64'h1800_1838_6066_3c00, 64'h003c_421a_3a22_1c00,
    64'h6666_667e_6666_3c00, 64'h3e66_663e_6666_3e00, 64'h3c66_0606_0666_3c00,
    64'h3e66_6666_6666_3e00, 64'h7e06_063e_0606_7e00, 64'h0606_063e_0606_7e00,
    64'h3c66_7606_0666_3c00, 64'h6666_667e_6666_6600, 64'h3c18_1818_1818_3c00,
    64'h1c36_3630_3030_7800, 64'h6636_1e0e_1e36_6600, 64'h7e06_0606_0606_0600,
    64'hc6c6_c6d6_feee_c600, 64'hc6c6_e6f6_dece_c600, 64'h3c66_6666_6666_3c00,
    64'h0606_3e66_6666_3e00, 64'h603c_7666_6666_3c00, 64'h6636_1e3e_6666_3e00,
    64'h3c66_603c_0666_3c00, 64'h1818_1818_185a_7e00, 64'h7c66_6666_6666_6600,
    64'h183c_6666_6666_6600, 64'hc6ee_fed6_c6c6_c600, 64'hc6c6_6c38_6cc6_c600,
    64'h1818_183c_6666_6600, 64'h7e06_0c18_3060_7e00, 64'h7818_1818_1818_7800,
    64'h0060_3018_0c06_0000, 64'h0060_3018_0c06_0000, 64'h0000_0082_4428_1000,
    64'h3c00_0000_0000_0000, 64'h0000_0000_6030_3000, 64'h7c66_7c60_3c00_0000,
    64'h3e66_663e_0606_0600, 64'h3c66_0666_3c00_0000, 64'h7c66_667c_6060_6000,
    64'h3c06_7e66_3c00_0000, 64'h0c0c_3e0c_0c6c_3800, 64'h3c60_7c66_667c_0000,
    64'h6666_663e_0606_0600, 64'h3c18_1818_0018_0000, 64'h1c36_3630_3000_3000,
    64'h6636_1e36_6606_0600, 64'h1818_1818_1818_1800, 64'hd6d6_feee_c600_0000,
    64'h6666_667e_3e00_0000, 64'h3c66_6666_3c00_0000, 64'h0606_3e66_663e_0000,
    64'hf0b0_3c36_363c_0000, 64'h0606_6666_3e00_0000, 64'h3e40_3c02_7c00_0000,
    64'h1818_187e_1818_0000, 64'h7c66_6666_6600_0000, 64'h183c_6666_0000_0000,
    64'h7cd6_d6d6_c600_0000, 64'h663c_183c_6600_0000, 64'h3c60_7c66_6600_0000,
    64'h3c0c_1830_3c00_0000, 64'h7018_180c_1818_7000, 64'h0018_1818_1818_1800,
    64'h0e18_1830_1818_0e00, 64'h0000_0036_5c00_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000
  };

  // Every input of the block has a known value from time zero on.
  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic [7:0] char_code     = '0;
  logic [2:0] module_number = '0;
  logic [1:0] quarter_turns = '0;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic [3:0] reg_address;
  logic [7:0] reg_data;
  logic       frame_end;
  logic       last;

  // Predicted contents of the frame buffer and the pairs still to come.
  logic [7:0]    shown_rows [BUF_ROWS];
  refresh_pair_t pending_pairs [$];
  int            errors = 0;

  // When quiet is set, neither side idles. It is written with nonblocking
  // assignments so that the stall process never races the test sequence.
  bit quiet = 1'b0;

  // A long hold-off is requested by bumping holdoff_reqs; the stall process
  // notices the change on the next edge and counts the stretch down itself.
  int holdoff_reqs   = 0;
  int holdoff_served = 0;
  int holdoff_left   = 0;

  led_matrix_char_rotate_refresh_top #(
    .MODULES(MODULES)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .module_number(module_number),
    .quarter_turns(quarter_turns),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .reg_address  (reg_address),
    .reg_data     (reg_data),
    .frame_end    (frame_end),
    .last         (last)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // One quarter turn: the glyph is transposed and then its row order reversed.
  // Bit r of input row c lands in column c of output row r.
  function automatic bitmap_t turn_quarter(input bitmap_t g);
    bitmap_t t;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        t[r][7 - c] = g[c][r];
      end
    end
    return t;
  endfunction

  // Applies one accepted character to the predicted frame buffer and queues
  // the full chain refresh that must follow it. The refresh walks the columns
  // in order and, within a column, the modules in chain order.
  function automatic void predict_refresh(input logic [7:0] code, input logic [2:0] mod,
                                          input logic [1:0] turns);
    bitmap_t       glyph;
    int            base;
    refresh_pair_t pair;
    if (code >= CODE_FIRST && code <= CODE_LAST) begin
      glyph = FONT_ROWS[code - CODE_FIRST];
    end else begin
      glyph = '0;
    end
    for (int i = 0; i < turns; i++) begin
      glyph = turn_quarter(glyph);
    end
    // A module number outside the chain leaves the buffer as it was, but the
    // refresh still goes out.
    if (mod >= 1 && mod <= MODULES) begin
      base = (MODULES - mod) * 8;
      for (int i = 0; i < 8; i++) begin
        shown_rows[base + i] = glyph[i];
      end
    end
    for (int col = 0; col < 8; col++) begin
      for (int k = 0; k < MODULES; k++) begin
        pair.address   = 4'(col + 1);
        pair.data      = shown_rows[col + 8 * k];
        pair.frame_end = (k == MODULES - 1);
        pair.last      = pair.frame_end && (col == 7);
        pending_pairs.push_back(pair);
      end
    end
  endfunction

  // Number of idle cycles before the next character is offered. Most gaps are
  // short; now and then a long one lets the offer land in any phase of the
  // block's work on the previous character.
  function automatic int sender_gap();
    int gap = 0;
    if (quiet) begin
      return 0;
    end
    if ($urandom_range(15) == 0) begin
      return $urandom_range(50, 1);
    end
    while ($urandom_range(99) < 32 && gap < 12) begin
      gap++;
    end
    return gap;
  endfunction

  // Offers one character and returns at the edge where its transfer happens.
  // Valid stays high on return so that the next character can follow at once;
  // the payload only changes while nothing is offered or right after a transfer.
  task automatic send_char(input logic [7:0] code, input logic [2:0] mod,
                           input logic [1:0] turns);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_code     <= code;
    module_number <= mod;
    quarter_turns <= turns;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_refresh(code, mod, turns);
  endtask

  // Mostly printable characters for modules in the chain, with some codes
  // without a glyph and some module numbers outside the chain mixed in.
  task automatic send_random_char();
    logic [7:0] code;
    logic [2:0] mod;
    if ($urandom_range(9) == 0) begin
      code = $urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom_range(255, 129));
    end else begin
      code = 8'($urandom_range(CODE_LAST, CODE_FIRST));
    end
    if ($urandom_range(9) == 0) begin
      mod = $urandom_range(1) ? 3'd0 : 3'($urandom_range(7, MODULES + 1));
    end else begin
      mod = 3'($urandom_range(MODULES, 1));
    end
    send_char(code, mod, 2'($urandom_range(3)));
  endtask

  // Stops offering and waits until every predicted pair has been seen.
  task automatic wait_refresh_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The buffer must read as all zeros after reset. A module number of zero
  // writes nothing, so the first refresh shows the reset contents.
  task automatic test_reset_state();
    send_char("A", 3'd0, 2'd0);
    wait_refresh_done();
  endtask

  // The first and last codes of the font, with the blank glyphs at its end.
  task automatic test_char_extremes();
    send_char(" ", 3'd1, 2'd0);
    send_char(CODE_LAST, 3'd2, 2'd1);
    send_char("!", 3'd4, 2'd2);
    send_char(8'd127, 3'd3, 2'd3);
    wait_refresh_done();
  endtask

  // Every number of quarter turns, on glyphs that differ under each turn.
  task automatic test_rotations();
    send_char("A", 3'd1, 2'd0);
    send_char("A", 3'd2, 2'd1);
    send_char("A", 3'd3, 2'd2);
    send_char("A", 3'd4, 2'd3);
    send_char("R", 3'd4, 2'd1);
    send_char("F", 3'd1, 2'd3);
    send_char("%", 3'd2, 2'd2);
    send_char("~", 3'd3, 2'd0);
    wait_refresh_done();
  endtask

  // Codes outside the font show blank; module numbers outside the chain
  // leave the buffer untouched. The buffer is full of glyphs by now, so
  // both cases are visible in the refresh.
  task automatic test_out_of_range();
    send_char(8'd0, 3'd1, 2'd1);
    send_char(8'd31, 3'd2, 2'd0);
    send_char(8'd129, 3'd3, 2'd2);
    send_char(8'd255, 3'd4, 2'd3);
    send_char("B", 3'd0, 2'd1);
    send_char("B", 3'd5, 2'd0);
    send_char("B", 3'd7, 2'd3);
    wait_refresh_done();
  endtask

  // The bulk of the run: random text with random idling on both sides.
  task automatic test_random_text();
    repeat (400) send_random_char();
    wait_refresh_done();
  endtask

  // A long stretch in which neither side ever idles.
  task automatic test_no_idle();
    quiet <= 1'b1;
    repeat (30) send_random_char();
    wait_refresh_done();
    quiet <= 1'b0;
  endtask

  // The receiver holds off for a long stretch while characters keep coming,
  // so the block fills up and stalls its input.
  task automatic test_output_holdoff();
    holdoff_reqs <= holdoff_reqs + 1;
    repeat (6) send_random_char();
    wait_refresh_done();
  endtask

  // Each character waits until the refresh of the one before it has drained.
  task automatic test_pause_between_items();
    repeat (8) begin
      send_random_char();
      wait_refresh_done();
    end
  endtask

  // The receiver stalls at random, except during a quiet stretch or the long
  // hold-off, which it counts down here.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      out_stall    <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_served != holdoff_reqs) begin
      holdoff_served <= holdoff_reqs;
      holdoff_left   <= HOLDOFF_CYCLES;
      out_stall      <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 32);
    end
  end

  // Every output transfer is compared with the oldest predicted pair.
  always @(posedge clk) begin : check_refresh
    refresh_pair_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected pair: reg_address %0d reg_data %02h", reg_address, reg_data);
        errors++;
      end else begin
        want = pending_pairs.pop_front();
        if (reg_address !== want.address) begin
          $error("reg_address: expected %0d, got %0d", want.address, reg_address);
          errors++;
        end
        if (reg_data !== want.data) begin
          $error("reg_data: expected %02h, got %02h", want.data, reg_data);
          errors++;
        end
        if (frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < BUF_ROWS; i++) begin
      shown_rows[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_char_extremes();
    test_rotations();
    test_out_of_range();
    test_random_text();
    test_no_idle();
    test_output_holdoff();
    test_pause_between_items();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Ends a run that hangs.
  initial begin
    #(LIMIT_TIME);
    $display("TB_ERROR");
    $finish;
  end

endmodule
